>>> src/rgbgc_pkg.sv
package rgbgc_pkg;

   localparam int RGBGC_MAX_RADIUS = 7;
   localparam int CHANNEL_BITS     = 16;
   localparam int WEIGHT_BITS      = 17;
   localparam int NUM_WEIGHTS      = 8;
   localparam int CSR_INDEX_BITS   = 3;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE  = 17'd65536;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ZERO = 17'd0;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_WEIGHT_CENTER = 3'd0;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic load_px;
      logic fill;
      logic shift;
      logic load_pair;
      logic mac_step;
      logic write_out;
      logic last_flag;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic mac_last;
   } status_type;

endpackage

>>> src/rgb_row_gaussian_convolver_core.sv
// An emitting request loads the folded tap pairs (PAIR), runs the shared MAC steps (MAC) and
// writes the output register (OUT) once it is free. Requests that emit nothing and do not
// end a row are taken at one per cycle; an emitting one keeps the block busy through its pass.
// Row end adds MAX_RADIUS window shifts plus one multiply-accumulate pass per flushed pixel.
// Reset (synchronous, active high): idle, row counters cleared, weights to identity kernel.
module rgb_row_gaussian_convolver_core #(
   parameter int MAX_RADIUS = rgbgc_pkg::RGBGC_MAX_RADIUS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rgbgc_pkg::CHANNEL_BITS-1:0]    req_red_in,
   input  logic [rgbgc_pkg::CHANNEL_BITS-1:0]    req_green_in,
   input  logic [rgbgc_pkg::CHANNEL_BITS-1:0]    req_blue_in,
   input  logic                                  req_row_last_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rgbgc_pkg::CHANNEL_BITS-1:0]    rsp_red_out,
   output logic [rgbgc_pkg::CHANNEL_BITS-1:0]    rsp_green_out,
   output logic [rgbgc_pkg::CHANNEL_BITS-1:0]    rsp_blue_out,
   output logic                                  rsp_row_last_out,
   input  logic                                  csr_write_enable,
   input  logic [rgbgc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rgbgc_pkg::WEIGHT_BITS-1:0]     csr_data
);
   import rgbgc_pkg::*;

   cmd_type    cmd;
   status_type stat;
   pixel_type  px_in;
   pixel_type  px_out;

   // Pack the request channels into one pixel
   assign px_in.red   = req_red_in;
   assign px_in.green = req_green_in;
   assign px_in.blue  = req_blue_in;

   // Sequencer: counts pending outputs, drives the right-edge flush
   rgbgc_ctrl #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_row_last_in(req_row_last_in),
      .req_ready      (req_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   // Window, folded-tap MAC, round/saturate and output register
   rgbgc_dp #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .px_in           (px_in),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .px_out          (px_out),
      .rsp_row_last_out(rsp_row_last_out)
   );

   assign rsp_red_out   = px_out.red;
   assign rsp_green_out = px_out.green;
   assign rsp_blue_out  = px_out.blue;

   // A row's last request always starts the flush, so the block goes busy
   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_row_last_in |=> !req_ready)
      else $error("row end did not start flush");

   // Never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |-> stat.out_free)
      else $error("output register overwritten");

   // No MAC step, pair load or flush shift while a new request enters the window
   a_no_mac_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load_px |-> !cmd.mac_step && !cmd.load_pair && !cmd.shift)
      else $error("request accepted during computation");

endmodule

>>> src/rgbgc_ctrl.sv
module rgbgc_ctrl #(
   parameter int MAX_RADIUS = rgbgc_pkg::RGBGC_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_row_last_in,
   output logic                  req_ready,
   input  rgbgc_pkg::status_type stat,
   output rgbgc_pkg::cmd_type    cmd
);
   import rgbgc_pkg::*;

   localparam int CW = $clog2(MAX_RADIUS + 2);

   typedef enum logic [2:0] {IDLE, PAIR, MAC, OUT, FLUSH} state_type;

   state_type       state_ff;
   logic [CW-1:0]   pending_ff;
   logic [CW-1:0]   step_ff;
   logic            started_ff;
   logic            last_ff;
   logic            flushing_ff;
   logic            flag_ff;

   logic [CW:0]     pend_inc;
   logic [CW:0]     step_sum;
   logic            emit_now;
   logic            accept;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign pend_inc  = {1'b0, pending_ff} + (CW+1)'(1);
   assign emit_now  = pend_inc > (CW+1)'(MAX_RADIUS);
   assign step_sum  = {1'b0, step_ff} + {1'b0, pending_ff};

   always_comb begin
      cmd           = '0;
      cmd.load_px   = accept;
      cmd.fill      = !started_ff;
      cmd.shift     = (state_ff == FLUSH);
      cmd.load_pair = (state_ff == PAIR);
      cmd.mac_step  = (state_ff == MAC);
      cmd.write_out = (state_ff == OUT) && stat.out_free;
      cmd.last_flag = flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         pending_ff  <= '0;
         step_ff     <= '0;
         started_ff  <= 1'b0;
         last_ff     <= 1'b0;
         flushing_ff <= 1'b0;
         flag_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  started_ff <= 1'b1;
                  last_ff    <= req_row_last_in;
                  flag_ff    <= 1'b0;
                  if (emit_now) begin
                     pending_ff <= CW'(MAX_RADIUS);
                     state_ff   <= PAIR;
                  end else begin
                     pending_ff <= pend_inc[CW-1:0];
                     if (req_row_last_in) begin
                        flushing_ff <= 1'b1;
                        step_ff     <= CW'(1);
                        state_ff    <= FLUSH;
                     end
                  end
               end
            end
            PAIR: state_ff <= MAC;
            MAC: begin
               if (stat.mac_last) begin
                  state_ff <= OUT;
               end
            end
            OUT: begin
               if (stat.out_free) begin
                  if (flushing_ff) begin
                     if (step_ff == CW'(MAX_RADIUS)) begin
                        pending_ff  <= '0;
                        started_ff  <= 1'b0;
                        flushing_ff <= 1'b0;
                        state_ff    <= IDLE;
                     end else begin
                        step_ff  <= step_ff + CW'(1);
                        state_ff <= FLUSH;
                     end
                  end else if (last_ff) begin
                     flushing_ff <= 1'b1;
                     step_ff     <= CW'(1);
                     state_ff    <= FLUSH;
                  end else begin
                     state_ff <= IDLE;
                  end
               end
            end
            FLUSH: begin
               if (step_sum > (CW+1)'(MAX_RADIUS)) begin
                  flag_ff  <= (step_ff == CW'(MAX_RADIUS));
                  state_ff <= PAIR;
               end else if (step_ff == CW'(MAX_RADIUS)) begin
                  pending_ff  <= '0;
                  started_ff  <= 1'b0;
                  flushing_ff <= 1'b0;
                  state_ff    <= IDLE;
               end else begin
                  step_ff <= step_ff + CW'(1);
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

>>> src/rgbgc_dp.sv
module rgbgc_dp #(
   parameter int MAX_RADIUS = rgbgc_pkg::RGBGC_MAX_RADIUS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [rgbgc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rgbgc_pkg::WEIGHT_BITS-1:0]       csr_data,
   input  rgbgc_pkg::pixel_type                    px_in,
   input  rgbgc_pkg::cmd_type                      cmd,
   output rgbgc_pkg::status_type                   stat,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output rgbgc_pkg::pixel_type                    px_out,
   output logic                                    rsp_row_last_out
);
   import rgbgc_pkg::*;

   localparam int WD = 2 * MAX_RADIUS + 1;
   localparam int NT = ((MAX_RADIUS < NUM_WEIGHTS - 1) ? MAX_RADIUS : NUM_WEIGHTS - 1) + 1;
   localparam int TW = $clog2(NT);
   localparam int SB = CHANNEL_BITS + 1;
   localparam int PB = SB + WEIGHT_BITS;
   localparam int AW = PB + $clog2(NT);

   logic [WEIGHT_BITS-1:0]  w_ff [NUM_WEIGHTS];
   pixel_type               win_ff [WD];
   logic [SB-1:0]           pair_ff [NT][3];
   logic [AW-1:0]           acc_ff [3];
   logic [TW-1:0]           tap_ff;
   logic                    rsp_valid_ff;
   pixel_type               out_ff;
   logic                    out_last_ff;

   logic [CHANNEL_BITS-1:0] win_ch [WD][3];
   logic [WEIGHT_BITS-1:0]  w_sel;
   logic [CHANNEL_BITS-1:0] res [3];
   pixel_type               new_px;

   assign new_px = cmd.load_px ? px_in : win_ff[0];
   assign w_sel  = w_ff[3'(tap_ff)];

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.mac_last = (tap_ff == TW'(NT - 1));

   always_comb begin
      for (int i = 0; i < WD; i++) begin
         win_ch[i][0] = win_ff[i].red;
         win_ch[i][1] = win_ff[i].green;
         win_ch[i][2] = win_ff[i].blue;
      end
   end

   // Round half up, then saturate to full scale
   always_comb begin
      logic [AW:0] rnd;
      for (int c = 0; c < 3; c++) begin
         rnd = {1'b0, acc_ff[c]} + (AW+1)'(32768);
         if (|rnd[AW:16+CHANNEL_BITS]) begin
            res[c] = '1;
         end else begin
            res[c] = rnd[16+CHANNEL_BITS-1:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff[0] <= WEIGHT_ONE;
         for (int i = 1; i < NUM_WEIGHTS; i++) begin
            w_ff[i] <= WEIGHT_ZERO;
         end
      end else if (csr_write_enable) begin
         w_ff[csr_index] <= csr_data;
      end
   end

   // Window: fill on the first pixel of a row, shift otherwise
   always_ff @(posedge clock) begin
      if (cmd.load_px || cmd.shift) begin
         if (cmd.load_px && cmd.fill) begin
            for (int i = 0; i < WD; i++) begin
               win_ff[i] <= px_in;
            end
         end else begin
            for (int i = WD - 1; i > 0; i--) begin
               win_ff[i] <= win_ff[i-1];
            end
            win_ff[0] <= new_px;
         end
      end
   end

   // Fold symmetric taps, then run one multiply-accumulate per tap distance
   always_ff @(posedge clock) begin
      if (cmd.load_pair) begin
         tap_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            acc_ff[c]     <= '0;
            pair_ff[0][c] <= {1'b0, win_ch[MAX_RADIUS][c]};
            for (int d = 1; d < NT; d++) begin
               pair_ff[d][c] <= {1'b0, win_ch[MAX_RADIUS-d][c]}
                              + {1'b0, win_ch[MAX_RADIUS+d][c]};
            end
         end
      end else if (cmd.mac_step) begin
         tap_ff <= tap_ff + TW'(1);
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_ff[c] + AW'(pair_ff[0][c] * w_sel);
            for (int d = 0; d < NT - 1; d++) begin
               pair_ff[d][c] <= pair_ff[d+1][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_out) begin
         out_ff.red   <= res[0];
         out_ff.green <= res[1];
         out_ff.blue  <= res[2];
         out_last_ff  <= cmd.last_flag;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign px_out           = out_ff;
   assign rsp_row_last_out = out_last_ff;

endmodule

>>> tb/tb_rgb_row_gaussian_convolver_core.sv
`timescale 1ns / 100ps

// Scoreboard: holds a row-pass blur predictor and the queue of expected
// blurred pixels it produces from the accepted requests.
class blur_scoreboard;
   localparam int RADIUS = rgbgc_pkg::RGBGC_MAX_RADIUS;
   localparam int DEPTH  = 2 * RADIUS + 1;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        row_last;
   } blurred_px_t;

   logic [rgbgc_pkg::WEIGHT_BITS-1:0] kernel[rgbgc_pkg::NUM_WEIGHTS];
   rgbgc_pkg::pixel_type window[DEPTH];
   int unsigned fill_count;
   int unsigned pending;
   blurred_px_t expected_px[$];
   int mismatches;

   function new();
      kernel[0] = rgbgc_pkg::WEIGHT_ONE;
      for (int i = 1; i < rgbgc_pkg::NUM_WEIGHTS; i++) kernel[i] = rgbgc_pkg::WEIGHT_ZERO;
      for (int i = 0; i < DEPTH; i++) window[i] = '0;
      fill_count = 0;
      pending = 0;
      mismatches = 0;
   endfunction

   function void set_weight(int idx, logic [rgbgc_pkg::WEIGHT_BITS-1:0] w);
      kernel[idx] = w;
   endfunction

   function void shift_px(rgbgc_pkg::pixel_type p);
      for (int i = DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = p;
   endfunction

   function logic [15:0] blur_channel(int ch);
      logic [63:0] acc;
      logic [63:0] px;
      int d;
      acc = 0;
      for (int i = 0; i < DEPTH; i++) begin
         d = (i >= RADIUS) ? i - RADIUS : RADIUS - i;
         px = (ch == 0) ? window[i].red : (ch == 1) ? window[i].green : window[i].blue;
         if (d < rgbgc_pkg::NUM_WEIGHTS) acc += px * kernel[d];
      end
      acc = (acc + 64'd32768) >> 16;
      return (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
   endfunction

   function void push_blurred(logic last);
      blurred_px_t b;
      b.red = blur_channel(0);
      b.green = blur_channel(1);
      b.blue = blur_channel(2);
      b.row_last = last;
      expected_px.push_back(b);
   endfunction

   function void note_request(rgbgc_pkg::pixel_type p, logic last);
      int unsigned left;
      if (fill_count == 0) begin
         for (int i = 0; i < DEPTH; i++) window[i] = p;
      end else begin
         shift_px(p);
      end
      if (fill_count < 15) fill_count++;
      pending++;
      if (pending > RADIUS) begin
         pending--;
         push_blurred(last && pending == 0);
      end
      if (last) begin
         left = pending;
         for (int s = 1; s <= RADIUS; s++) begin
            shift_px(p);
            if (s > RADIUS - left) push_blurred(s == RADIUS);
         end
         fill_count = 0;
         pending = 0;
      end
   endfunction

   function void check_result(blurred_px_t got);
      blurred_px_t exp_px;
      if (expected_px.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
         return;
      end
      exp_px = expected_px.pop_front();
      if (got !== exp_px) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: result mismatch exp r=%h g=%h b=%h l=%b got r=%h g=%h b=%h l=%b",
                     exp_px.red, exp_px.green, exp_px.blue, exp_px.row_last,
                     got.red, got.green, got.blue, got.row_last);
      end
   endfunction
endclass

module tb_rgb_row_gaussian_convolver_core;
   import rgbgc_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CHANNEL_BITS-1:0] req_red_in;
   logic [CHANNEL_BITS-1:0] req_green_in;
   logic [CHANNEL_BITS-1:0] req_blue_in;
   logic                   req_row_last_in;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CHANNEL_BITS-1:0] rsp_red_out;
   logic [CHANNEL_BITS-1:0] rsp_green_out;
   logic [CHANNEL_BITS-1:0] rsp_blue_out;
   logic                   rsp_row_last_out;
   logic                   csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [WEIGHT_BITS-1:0] csr_data;

   blur_scoreboard board;
   bit stimulus_done;
   bit sink_on;

   rgb_row_gaussian_convolver_core DUT (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Write one kernel weight into both the block and the predictor.
   // Leave the enable high; the caller drops it after the last write.
   task automatic write_weight(input int idx, input logic [WEIGHT_BITS-1:0] w);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_INDEX_BITS'(idx);
      csr_data <= w;
      @(posedge clock);
      board.set_weight(idx, w);
   endtask

   // Load a whole kernel; the block must be idle.
   task automatic load_kernel(input logic [WEIGHT_BITS-1:0] w[NUM_WEIGHTS]);
      for (int i = 0; i < NUM_WEIGHTS; i++) write_weight(i, w[i]);
      csr_write_enable <= 1'b0;
   endtask

   // Send one pixel request, after a random gap if gaps is set; hold it until accepted.
   // Valid stays high after acceptance until a later call with a gap or a drain drops it.
   task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic last, input bit gaps);
      int gap;
      pixel_type p;
      gap = gaps ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      req_row_last_in <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p.red = r;
      p.green = g;
      p.blue = b;
      board.note_request(p, last);
   endtask

   // Wait until every expected pixel has been drained, then let the block settle.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (board.expected_px.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Send a row of random pixels; mostly random content, sometimes extremes.
   task automatic send_row(input int len, input bit gaps);
      logic [15:0] c[3];
      for (int i = 0; i < len; i++) begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
               0: c[k] = 16'h0000;
               1: c[k] = 16'hFFFF;
               default: c[k] = 16'($urandom);
            endcase
         end
         send_pixel(c[0], c[1], c[2], i == len - 1, gaps);
      end
   endtask

   // Result side: draw a random stall per result, with stall-free stretches.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = sink_on ? $urandom_range(0, 17) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result({rsp_red_out, rsp_green_out, rsp_blue_out, rsp_row_last_out});
      end
   end

   initial begin
      logic [WEIGHT_BITS-1:0] kern[NUM_WEIGHTS];
      int total;
      board = new();
      stimulus_done = 0;
      sink_on = 1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_row_last_in = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity kernel, a single-pixel row, then a two-pixel row.
      send_pixel(16'hFFFF, 16'h0000, 16'h8001, 1'b1, 0);
      send_pixel(16'h0001, 16'hFFFF, 16'h0000, 1'b0, 0);
      send_pixel(16'h1234, 16'h8000, 16'hFFFF, 1'b1, 0);
      drain_block();

      // Saturating kernel: all weights at max out-of-range value.
      for (int i = 0; i < NUM_WEIGHTS; i++) kern[i] = 17'h1FFFF;
      load_kernel(kern);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
      send_pixel(16'h0000, 16'h0001, 16'h7FFF, 1'b0, 0);
      for (int i = 0; i < 8; i++)
         send_pixel(16'h0000, 16'h0000, 16'h0000, i == 7, 0);
      drain_block();

      // Half-rounding kernel: weight 0.5 in the center only.
      kern[0] = 17'd32768;
      for (int i = 1; i < NUM_WEIGHTS; i++) kern[i] = WEIGHT_ZERO;
      load_kernel(kern);
      send_pixel(16'h0001, 16'h0003, 16'hFFFF, 1'b0, 0);
      send_pixel(16'h0002, 16'h0005, 16'h0000, 1'b1, 0);
      drain_block();

      // Random phases: new kernel each phase, rows of mixed length.
      total = 0;
      for (int phase = 0; total < 210; phase++) begin
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            case ($urandom_range(0, 5))
               0: kern[i] = WEIGHT_ZERO;
               1: kern[i] = WEIGHT_ONE;
               2: kern[i] = 17'h1FFFF;
               default: kern[i] = 17'($urandom_range(0, 16384));
            endcase
         end
         load_kernel(kern);
         sink_on = (phase % 3) != 2;
         for (int r = 0; r < 3; r++) begin
            int len;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            send_row(len, phase % 4 != 3);
            total += len;
         end
         // Hold off sending until every expected result has come.
         drain_block();
      end
      sink_on = 1;
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (board.expected_px.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Generous watchdog, far above the slowest legal run.
   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
